>>> hw/rtl/png_row_unfilter_core_macros.svh
// Assertion helpers shared by the unfilter RTL.
// All checks are sampled on the rising clock edge and are off while reset is held.
`ifndef PNG_ROW_UNFILTER_CORE_MACROS_SVH
`define PNG_ROW_UNFILTER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PNG_RU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PNG_RU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/png_ru_pkg.sv
`timescale 1ns / 1ps

package png_ru_pkg;

    // Field and register widths.
    localparam int DATA_W      = 8;
    localparam int ROW_BYTES_W = 14;
    localparam int BPP_W       = 4;
    localparam int ROW_COUNT_W = 15;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 15;

    // Scanline filter types as coded in the stream.
    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } t_filter;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_BYTES = 2'd0,
        CFG_BPP       = 2'd1,
        CFG_ROW_COUNT = 2'd2
    } t_cfg_reg;

    // Neighbor bytes and filter handed to the predictor.
    typedef struct packed {
        t_filter           filter;
        logic [DATA_W-1:0] left;
        logic [DATA_W-1:0] up;
        logic [DATA_W-1:0] up_left;
    } t_taps;

endpackage

>>> hw/rtl/png_ru_line_store.sv
`timescale 1ns / 1ps

module png_ru_line_store
    import png_ru_pkg::*;
#(
    parameter int DEPTH  = 8192,
    parameter int ADDR_W = 13
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // One write port, one read port with registered data.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/png_ru_predict.sv
`timescale 1ns / 1ps

module png_ru_predict
    import png_ru_pkg::*;
(
    input  t_taps             i_taps,
    input  logic [DATA_W-1:0] i_data,
    output logic [DATA_W-1:0] o_pixel
);

    logic signed [DATA_W+1:0] a_s;
    logic signed [DATA_W+1:0] b_s;
    logic signed [DATA_W+1:0] c_s;
    logic signed [DATA_W+1:0] diff_a;
    logic signed [DATA_W+1:0] diff_b;
    logic signed [DATA_W+1:0] diff_c;
    logic        [DATA_W+1:0] dist_a;
    logic        [DATA_W+1:0] dist_b;
    logic        [DATA_W+1:0] dist_c;
    logic        [DATA_W-1:0] paeth;
    logic        [DATA_W:0]   avg_sum;
    logic        [DATA_W-1:0] pred;

    // Paeth distances: |p-a| = |b-c|, |p-b| = |a-c|, |p-c| = |a+b-2c|.
    always_comb begin
        a_s    = signed'({2'b00, i_taps.left});
        b_s    = signed'({2'b00, i_taps.up});
        c_s    = signed'({2'b00, i_taps.up_left});
        diff_a = b_s - c_s;
        diff_b = a_s - c_s;
        diff_c = a_s + b_s - c_s - c_s;
        dist_a = (diff_a < 0) ? unsigned'(-diff_a) : unsigned'(diff_a);
        dist_b = (diff_b < 0) ? unsigned'(-diff_b) : unsigned'(diff_b);
        dist_c = (diff_c < 0) ? unsigned'(-diff_c) : unsigned'(diff_c);
        if (dist_a <= dist_b && dist_a <= dist_c) begin
            paeth = i_taps.left;
        end else if (dist_b <= dist_c) begin
            paeth = i_taps.up;
        end else begin
            paeth = i_taps.up_left;
        end
    end

    // Select the prediction and add it to the filtered byte modulo 256.
    always_comb begin
        avg_sum = {1'b0, i_taps.left} + {1'b0, i_taps.up};
        case (i_taps.filter)
            FILT_SUB:   pred = i_taps.left;
            FILT_UP:    pred = i_taps.up;
            FILT_AVG:   pred = avg_sum[DATA_W:1];
            FILT_PAETH: pred = paeth;
            default:    pred = '0;
        endcase
        o_pixel = i_data + pred;
    end

endmodule

>>> hw/rtl/png_row_unfilter_core.sv
`timescale 1ns / 1ps
`include "png_row_unfilter_core_macros.svh"

// PNG scanline unfilter. Takes the inflated image stream one byte per cycle: the
// first byte of each row is its filter type, the next row_bytes bytes are filtered
// samples, each reconstructed with None, Sub, Up, Average or Paeth and sent out in the
// cycle after it is accepted, with tlast on the last byte of the row. A new byte can
// be accepted in every cycle; the input is held off only while a result waits on a
// stalled output or while halted. The rate is set by the line store, which holds the
// prior row with one write and one registered read per cycle; its read for the next
// byte is issued at the edge that accepts the current one. The first row sees an
// all-zero prior row. A filter byte above 4 in a kept row gives one result with tuser
// set, then holds input off until reset. Rows after row_count are consumed silently.
module png_row_unfilter_core
    import png_ru_pkg::*;
#(
    parameter int MAX_ROW_BYTES   = 8192,
    parameter int MAX_PIXEL_BYTES = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input stream.
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [DATA_W-1:0]     i_s_axis_tdata,   // [7:0] data_byte
    // Output stream.
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [DATA_W-1:0]     o_m_axis_tdata,   // [7:0] pixel_byte
    output logic                  o_m_axis_tlast,   // row_end
    output logic                  o_m_axis_tuser,   // bad_filter
    // Configuration writes.
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int ADDR_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int IDX_W  = (ADDR_W > ROW_BYTES_W) ? ADDR_W : ROW_BYTES_W;
    localparam int SEL_W  = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam logic [IDX_W-1:0] MAX_LEN = IDX_W'(MAX_ROW_BYTES);
    localparam logic [BPP_W-1:0] MAX_BPP = BPP_W'(MAX_PIXEL_BYTES);

    // Configuration registers.
    logic [ROW_BYTES_W-1:0] r_row_bytes;
    logic [BPP_W-1:0]       r_bpp;
    logic [ROW_COUNT_W-1:0] r_row_count;

    // Row state.
    logic [ROW_BYTES_W-1:0] r_pos;
    logic [ROW_BYTES_W-1:0] n_pos;
    t_filter                r_filter;
    t_filter                n_filter;
    logic [ROW_COUNT_W-1:0] r_rows_done;
    logic [ROW_COUNT_W-1:0] n_rows_done;
    logic                   r_halted;
    logic                   n_halted;
    logic [DATA_W-1:0]      r_left [MAX_PIXEL_BYTES];
    logic [DATA_W-1:0]      r_up_left [MAX_PIXEL_BYTES];

    // Output register.
    logic                   r_out_valid;
    logic                   n_out_valid;
    logic [DATA_W-1:0]      r_out_data;
    logic [DATA_W-1:0]      n_out_data;
    logic                   r_out_last;
    logic                   n_out_last;
    logic                   r_out_bad;
    logic                   n_out_bad;

    logic                   accept;
    logic                   keep;
    logic                   is_filter_byte;
    logic                   bad_type;
    logic                   last;
    logic                   clear_hist;
    logic                   shift_hist;
    logic [IDX_W-1:0]       eff_len;
    logic [IDX_W-1:0]       pos_ext;
    logic [IDX_W-1:0]       pos_m1;
    logic [IDX_W-1:0]       next_m1;
    logic [ADDR_W-1:0]      wr_addr;
    logic [ADDR_W-1:0]      rd_addr;
    logic [BPP_W-1:0]       eff_bpp;
    logic [BPP_W-1:0]       bpp_m1;
    logic [SEL_W-1:0]       tap_sel;
    logic [DATA_W-1:0]      store_rd;
    logic [DATA_W-1:0]      up_byte;
    logic [DATA_W-1:0]      pixel;
    t_taps                  taps;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_bytes <= ROW_BYTES_W'(1);
            r_bpp       <= BPP_W'(1);
            r_row_count <= ROW_COUNT_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROW_BYTES: r_row_bytes <= i_cfg_data[ROW_BYTES_W-1:0];
                CFG_BPP:       r_bpp       <= i_cfg_data[BPP_W-1:0];
                CFG_ROW_COUNT: r_row_count <= i_cfg_data[ROW_COUNT_W-1:0];
                default:       ;
            endcase
        end
    end

    // Clamp row length and pixel size to their supported ranges.
    always_comb begin
        eff_len = IDX_W'(r_row_bytes);
        if (eff_len == '0) begin
            eff_len = IDX_W'(1);
        end else if (eff_len > MAX_LEN) begin
            eff_len = MAX_LEN;
        end
        eff_bpp = r_bpp;
        if (eff_bpp == '0) begin
            eff_bpp = BPP_W'(1);
        end else if (eff_bpp > MAX_BPP) begin
            eff_bpp = MAX_BPP;
        end
        bpp_m1  = eff_bpp - BPP_W'(1);
        tap_sel = SEL_W'(bpp_m1);
    end

    // Input is taken when not halted and the output slot is free or draining.
    assign o_s_axis_tready = !r_halted && (!r_out_valid || i_m_axis_tready);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign keep            = r_rows_done < r_row_count;
    assign is_filter_byte  = (r_pos == '0);
    assign bad_type        = i_s_axis_tdata > DATA_W'(FILT_PAETH);
    assign pos_ext         = IDX_W'(r_pos);
    assign pos_m1          = pos_ext - IDX_W'(1);
    assign last            = pos_ext >= eff_len;
    assign wr_addr         = pos_m1[ADDR_W-1:0];

    // Neighbor taps: prior row is zero on the first image row.
    assign up_byte       = (r_rows_done == '0) ? '0 : store_rd;
    assign taps.filter   = r_filter;
    assign taps.left     = r_left[tap_sel];
    assign taps.up       = up_byte;
    assign taps.up_left  = r_up_left[tap_sel];

    png_ru_predict u_predict (
        .i_taps  (taps),
        .i_data  (i_s_axis_tdata),
        .o_pixel (pixel)
    );

    // Row sequencing and result formation.
    always_comb begin
        n_pos       = r_pos;
        n_filter    = r_filter;
        n_rows_done = r_rows_done;
        n_halted    = r_halted;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        n_out_bad   = r_out_bad;
        clear_hist  = 1'b0;
        shift_hist  = 1'b0;
        if (accept) begin
            if (is_filter_byte) begin
                clear_hist = 1'b1;
                n_pos      = ROW_BYTES_W'(1);
                if (keep) begin
                    if (bad_type) begin
                        n_halted    = 1'b1;
                        n_pos       = '0;
                        n_out_valid = 1'b1;
                        n_out_data  = '0;
                        n_out_last  = 1'b0;
                        n_out_bad   = 1'b1;
                    end else begin
                        n_filter = t_filter'(i_s_axis_tdata[2:0]);
                    end
                end
            end else begin
                n_pos = last ? '0 : r_pos + ROW_BYTES_W'(1);
                if (keep) begin
                    shift_hist  = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_data  = pixel;
                    n_out_last  = last;
                    n_out_bad   = 1'b0;
                    if (last) begin
                        n_rows_done = r_rows_done + ROW_COUNT_W'(1);
                    end
                end
            end
        end
    end

    // Prefetch the prior-row byte for the next sample position.
    always_comb begin
        next_m1 = IDX_W'(n_pos) - IDX_W'(1);
        rd_addr = (n_pos == '0) ? '0 : next_m1[ADDR_W-1:0];
    end

    png_ru_line_store #(
        .DEPTH  (MAX_ROW_BYTES),
        .ADDR_W (ADDR_W)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (shift_hist),
        .i_wr_addr (wr_addr),
        .i_wr_data (pixel),
        .i_rd_addr (rd_addr),
        .o_rd_data (store_rd)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_filter    <= FILT_NONE;
            r_rows_done <= '0;
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_filter    <= n_filter;
            r_rows_done <= n_rows_done;
            r_halted    <= n_halted;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
        r_out_bad  <= n_out_bad;
    end

    // Left and upper-left byte histories, newest in entry zero.
    always_ff @(posedge i_clk) begin
        if (clear_hist) begin
            for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
                r_left[i]    <= '0;
                r_up_left[i] <= '0;
            end
        end else if (shift_hist) begin
            r_left[0]    <= pixel;
            r_up_left[0] <= up_byte;
            for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
                r_left[i]    <= r_left[i-1];
                r_up_left[i] <= r_up_left[i-1];
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_bad;

    `PNG_RU_ASSERT_SAME(a_halt_blocks_input, r_halted, !o_s_axis_tready, "input taken after halt")
    `PNG_RU_ASSERT_SAME(a_bad_result_clean, o_m_axis_tvalid && o_m_axis_tuser,
        r_halted && o_m_axis_tdata == '0 && !o_m_axis_tlast, "malformed bad-filter result")
    `PNG_RU_ASSERT_NEXT(a_result_kept, r_out_valid && !i_m_axis_tready, r_out_valid,
        "pending result dropped")
    `PNG_RU_ASSERT_NEXT(a_rows_step, accept && !is_filter_byte && keep && last,
        r_rows_done == $past(r_rows_done) + ROW_COUNT_W'(1), "row count not advanced")

endmodule

>>> sim/png_row_unfilter_core_tb.sv
`timescale 1ns / 1ps

module png_row_unfilter_core_tb;
    import png_ru_pkg::*;

    localparam int LINE_DEPTH  = 8192;
    localparam int PIXEL_MAX   = 8;
    localparam int HOLD_CYCLES = 250;

    // One reconstructed byte as it leaves the block.
    typedef struct packed {
        logic [DATA_W-1:0] pix;
        logic              row_end;
        logic              bad;
    } t_pixel;

    // Scoreboard: rebuilds each scanline byte and keeps the bytes still due.
    class pixel_scoreboard;
        logic [DATA_W-1:0]      line_mem [LINE_DEPTH];
        logic [63:0]            left_hist;
        logic [63:0]            upleft_hist;
        int unsigned            pos;
        t_filter                kind;
        int unsigned            rows_done;
        bit                     halted;
        int unsigned            filled;
        logic [ROW_BYTES_W-1:0] row_bytes;
        logic [BPP_W-1:0]       pix_bytes;
        logic [ROW_COUNT_W-1:0] row_count;
        t_pixel                 pixels_due [$];
        int                     mismatches;

        function new();
            foreach (line_mem[i]) line_mem[i] = '0;
            left_hist   = '0;
            upleft_hist = '0;
            pos         = 0;
            kind        = FILT_NONE;
            rows_done   = 0;
            halted      = 1'b0;
            filled      = 0;
            row_bytes   = ROW_BYTES_W'(1);
            pix_bytes   = BPP_W'(1);
            row_count   = ROW_COUNT_W'(1);
            mismatches  = 0;
        endfunction

        function void set_reg(t_cfg_reg idx, int unsigned v);
            case (idx)
                CFG_ROW_BYTES: row_bytes = v[ROW_BYTES_W-1:0];
                CFG_BPP:       pix_bytes = v[BPP_W-1:0];
                CFG_ROW_COUNT: row_count = v[ROW_COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned row_len();
            if (row_bytes == 0) return 1;
            if (row_bytes > LINE_DEPTH) return LINE_DEPTH;
            return row_bytes;
        endfunction

        function int unsigned pixel_len();
            if (pix_bytes == 0) return 1;
            if (pix_bytes > PIXEL_MAX) return PIXEL_MAX;
            return pix_bytes;
        endfunction

        function bit row_kept();
            return rows_done < row_count;
        endfunction

        function int pending();
            return pixels_due.size();
        endfunction

        function logic [DATA_W-1:0] paeth(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                                          logic [DATA_W-1:0] c);
            int p, da, db, dc;
            p  = int'(a) + int'(b) - int'(c);
            da = (p > int'(a)) ? p - int'(a) : int'(a) - p;
            db = (p > int'(b)) ? p - int'(b) : int'(b) - p;
            dc = (p > int'(c)) ? p - int'(c) : int'(c) - p;
            if (da <= db && da <= dc) return a;
            if (db <= dc) return b;
            return c;
        endfunction

        // Rebuild the byte that an accepted stream byte gives, if any.
        function void take_stream_byte(logic [DATA_W-1:0] x);
            int unsigned       len, idx, shift;
            bit                keep, last;
            logic [DATA_W-1:0] a, b, c, pred, r;
            logic [DATA_W:0]   sum;
            t_pixel            res;
            len  = row_len();
            keep = row_kept();
            if (halted) return;

            // Filter type byte at the start of a row.
            if (pos == 0) begin
                left_hist   = '0;
                upleft_hist = '0;
                pos         = 1;
                if (keep) begin
                    if (x > 8'd4) begin
                        halted  = 1'b1;
                        pos     = 0;
                        res.pix = '0;
                        res.row_end = 1'b0;
                        res.bad = 1'b1;
                        pixels_due.push_back(res);
                        return;
                    end
                    kind = t_filter'(x[2:0]);
                end
                return;
            end

            idx   = (pos - 1) % LINE_DEPTH;
            last  = (pos >= len);
            shift = (pixel_len() - 1) * 8;
            pos   = last ? 0 : pos + 1;
            if (!keep) return;

            a = DATA_W'(left_hist >> shift);
            b = (rows_done == 0) ? '0 : line_mem[idx];
            c = DATA_W'(upleft_hist >> shift);
            case (kind)
                FILT_SUB:   pred = a;
                FILT_UP:    pred = b;
                FILT_AVG: begin
                    sum  = {1'b0, a} + {1'b0, b};
                    pred = sum[DATA_W:1];
                end
                FILT_PAETH: pred = paeth(a, b, c);
                default:    pred = '0;
            endcase
            r = x + pred;

            line_mem[idx] = r;
            if (idx + 1 > filled) filled = idx + 1;
            left_hist   = {left_hist[55:0], r};
            upleft_hist = {upleft_hist[55:0], b};
            if (last) rows_done++;

            res.pix     = r;
            res.row_end = last;
            res.bad     = 1'b0;
            pixels_due.push_back(res);
        endfunction

        // Compare one output byte with the oldest byte due.
        function void match_pixel(logic [DATA_W-1:0] pix, logic row_end, logic bad);
            t_pixel want;
            if (pixels_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected output pix=%02h last=%b bad=%b",
                             pix, row_end, bad);
                return;
            end
            want = pixels_due.pop_front();
            if (pix !== want.pix || row_end !== want.row_end || bad !== want.bad) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: expected pix=%02h last=%b bad=%b, got pix=%02h last=%b bad=%b",
                             want.pix, want.row_end, want.bad, pix, row_end, bad);
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [DATA_W-1:0]     m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    pixel_scoreboard sb;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_seq = 0;

    png_row_unfilter_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    // Clock generation.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    always @(posedge i_clk) begin
        static int hold_seen = 0;
        static int hold_left = 0;
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Output monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && sb != null && m_tvalid && m_tready)
            sb.match_pixel(m_tdata, m_tlast, m_tuser);
    end

    // Offer one stream byte and wait until the block takes it.
    task automatic send_byte(input logic [DATA_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge i_clk); while (!s_tready);
        sb.take_stream_byte(b);
    endtask

    // Stop sending and wait until every byte due has come out.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() > 0);
        repeat (4) @(posedge i_clk);
    endtask

    // One register write, with the write enable driven low again before the task returns.
    task automatic cfg_write(input t_cfg_reg idx, input int unsigned v);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= v[CFG_DATA_W-1:0];
        @(posedge i_clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, v);
        @(posedge i_clk);
    endtask

    function automatic logic [DATA_W-1:0] rand_sample();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return DATA_W'($urandom_range(255));
        endcase
    endfunction

    task automatic send_row(input logic [DATA_W-1:0] filt, input int unsigned n);
        send_byte(filt);
        repeat (n) send_byte(rand_sample());
    endtask

    // Main stimulus.
    initial begin
        logic [DATA_W-1:0] first_row [8] = '{8'h00, 8'hFF, 8'h80, 8'h7F,
                                             8'h01, 8'hFE, 8'h55, 8'hAA};
        int phase_idle [4]  = '{0, 59, 0, 15};
        int phase_stall [4] = '{0, 0, 59, 15};
        int seg_items, rows, len;
        bit keep;

        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // First row: prior row reads as zero. It also sets the longest row used later.
        cfg_write(CFG_ROW_BYTES, 20);
        cfg_write(CFG_BPP, 1);
        cfg_write(CFG_ROW_COUNT, 32767);
        // The receiver holds off while this row is offered, so the input stalls.
        hold_seq++;
        send_byte(DATA_W'(FILT_SUB));
        foreach (first_row[i]) send_byte(first_row[i]);
        repeat (12) send_byte(rand_sample());

        // Filter types None, Up, Average and Paeth on short rows with extreme bytes.
        drain();
        cfg_write(CFG_ROW_BYTES, 3);
        send_byte(DATA_W'(FILT_NONE));
        send_byte(8'hFF); send_byte(8'h00); send_byte(8'hAA);
        send_byte(DATA_W'(FILT_UP));
        send_byte(8'hFF); send_byte(8'h00); send_byte(8'hAA);
        send_byte(DATA_W'(FILT_AVG));
        send_byte(8'hFF); send_byte(8'hFF); send_byte(8'h01);
        send_byte(DATA_W'(FILT_PAETH));
        send_byte(8'h00); send_byte(8'hFF); send_byte(8'h80);
        drain();
        cfg_write(CFG_BPP, 8);
        send_row(DATA_W'(FILT_PAETH), 3);

        // Row length and pixel size of zero are taken as one.
        drain();
        cfg_write(CFG_ROW_BYTES, 0);
        cfg_write(CFG_BPP, 0);
        send_row(DATA_W'(FILT_AVG), 1);

        // Row count of zero: rows are consumed silently, even with oversized settings.
        drain();
        cfg_write(CFG_ROW_COUNT, 0);
        cfg_write(CFG_ROW_BYTES, 16383);
        cfg_write(CFG_BPP, 15);
        send_row(8'hFF, 5);
        drain();
        cfg_write(CFG_ROW_BYTES, 2);
        send_byte(rand_sample());
        send_row(8'h07, 2);

        // Row length cut below the current position: the next byte ends the row.
        drain();
        cfg_write(CFG_ROW_COUNT, sb.rows_done + 1);
        cfg_write(CFG_ROW_BYTES, 10);
        cfg_write(CFG_BPP, 3);
        send_row(DATA_W'(FILT_UP), 6);
        drain();
        cfg_write(CFG_ROW_BYTES, 4);
        send_byte(rand_sample());
        // Row count reached: this row is dropped and its filter byte not checked.
        send_row(8'hC8, 4);

        // Random rows under each idling pattern, with a new setting per segment.
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = phase_idle[ph];
            recv_stall_pct = phase_stall[ph];
            for (int seg = 0; seg < 4; seg++) begin
                drain();
                cfg_write(CFG_ROW_BYTES,
                          ($urandom_range(9) == 0) ? 0 : $urandom_range(1, sb.filled));
                if ($urandom_range(9) == 0)
                    cfg_write(CFG_BPP, $urandom_range(1) ? 0 : 15);
                else
                    cfg_write(CFG_BPP, $urandom_range(1, 8));
                case ($urandom_range(3))
                    0:       cfg_write(CFG_ROW_COUNT, sb.rows_done + $urandom_range(1));
                    1:       cfg_write(CFG_ROW_COUNT, 32767);
                    default: cfg_write(CFG_ROW_COUNT, sb.rows_done + 50);
                endcase
                seg_items = 0;
                rows = 0;
                while (seg_items < 24 && rows < 12) begin
                    // Long output hold-off while the sender keeps offering.
                    if (ph == 0 && seg == 2 && rows == 1) hold_seq++;
                    len  = sb.row_len();
                    keep = sb.row_kept();
                    if (keep)
                        send_row(DATA_W'($urandom_range(4)), len);
                    else
                        send_row(DATA_W'($urandom_range(255)), len);
                    seg_items += len + 1;
                    rows++;
                end
            end
        end

        // Bad filter byte on a kept row; the block halts after it.
        send_idle_pct  = 0;
        recv_stall_pct = 15;
        drain();
        cfg_write(CFG_ROW_COUNT, 32767);
        send_byte(DATA_W'($urandom_range(5, 255)));

        drain();
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Run time limit.
    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/png_ru_pkg.sv
hw/rtl/png_ru_line_store.sv
hw/rtl/png_ru_predict.sv
hw/rtl/png_row_unfilter_core.sv
sim/png_row_unfilter_core_tb.sv
